// ----- rtl/antenna_gain_table_interpolator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Antenna gain table interpolator assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ANTENNA_GAIN_TABLE_INTERPOLATOR_TOP_DEFINES_SVH
`define ANTENNA_GAIN_TABLE_INTERPOLATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Assert a property on the rising edge, held off during reset.
`define AGTI_ASSERT(lbl, ck, rn, prop) \
lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
	else $error("agti: assertion failed");
// Assert that a condition implies an expression in the following cycle.
`define AGTI_ASSERT_NEXT(lbl, ck, rn, cond, expr) \
lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
	else $error("agti: next-cycle assertion failed");
`else
`define AGTI_ASSERT(lbl, ck, rn, prop)
`define AGTI_ASSERT_NEXT(lbl, ck, rn, cond, expr)
`endif

`endif

// ----- rtl/agti_pkg.sv -----
// ----------------------------------------------------------------------------
// Antenna gain table interpolator package
// Shared widths, codes, types and the angle wrap function.
// ----------------------------------------------------------------------------
package agti_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int TABLE_DEPTH = 360;
	localparam int IDX_W       = 9;
	localparam int ENTRY_W     = 16;
	localparam int AZ_W        = 19;
	localparam int EL_W        = 18;
	localparam int GAIN_W      = 18;
	localparam int OP_W        = 2;
	localparam int ANGLE_W     = IDX_W + FRAC_BITS;

	localparam int GAIN_MAX = 98303;
	localparam int GAIN_MIN = -98304;

	// One full turn in angle units
	localparam int CIRCLE       = TABLE_DEPTH << FRAC_BITS;
	// Offset that lifts any AZ_W-bit signed angle to a non-negative value
	localparam int WRAP_OFS_MUL = ((2 ** (AZ_W - 1)) + CIRCLE - 1) / CIRCLE;
	localparam int WRAP_OFS     = WRAP_OFS_MUL * CIRCLE;
	localparam int WRAP_W       = $clog2(2 * WRAP_OFS);
	localparam int WRAP_STEPS   = $clog2(2 * WRAP_OFS_MUL);

	// Result queue
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = 3;
	localparam int QCNT_W      = 4;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [0:0] REG_PEAK_GAIN = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_QUERY    = 2'd0,
		OP_WR_HORIZ = 2'd1,
		OP_WR_VERT  = 2'd2
	} op_t;

	typedef struct packed {
		logic                      we;
		logic [IDX_W-1:0]          addr;
		logic signed [ENTRY_W-1:0] data;
	} ram_wr_t;

	// Reduce an angle modulo one turn by a short chain of conditional subtracts
	function automatic logic [ANGLE_W-1:0] wrap_angle(input logic signed [AZ_W-1:0] a);
		logic [WRAP_W-1:0] x;
		logic [WRAP_W-1:0] step;
		x = WRAP_W'(int'(a) + WRAP_OFS);
		for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
			step = WRAP_W'(CIRCLE << k);
			if (x >= step) begin
				x = x - step;
			end
		end
		return ANGLE_W'(x);
	endfunction

endpackage

// ----- rtl/antenna_gain_table_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// Antenna gain table interpolator
// Two 360-entry attenuation tables with linear interpolation between whole
// degrees; returns peak gain less horizontal and vertical attenuation.
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    operation, table_index, entry_gain,
//                                        azimuth, elevation
//   gain      gain_valid / gain_stall    total_gain
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item enters per cycle while item_stall is low. A query result passes
// the input register, the table read, the interpolation register and the push
// into the result queue before it is offered on the gain channel.
// After reset a clearing pass zeroes all 360 entries of both tables, one entry
// per cycle; item_stall stays high throughout. Write items give no result.
// Up to eight queries may be outstanding; further transactions stall only
// when that many results are queued or in flight.
//
`include "antenna_gain_table_interpolator_top_defines.svh"

module antenna_gain_table_interpolator_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// item channel
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic [agti_pkg::OP_W-1:0]              operation,
	input  logic [agti_pkg::IDX_W-1:0]             table_index,
	input  logic signed [agti_pkg::ENTRY_W-1:0]    entry_gain,
	input  logic signed [agti_pkg::AZ_W-1:0]       azimuth,
	input  logic signed [agti_pkg::EL_W-1:0]       elevation,
	// gain channel
	output logic                                   gain_valid,
	input  logic                                   gain_stall,
	output logic signed [agti_pkg::GAIN_W-1:0]     total_gain,
	// configuration
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [agti_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [agti_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [agti_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                   pready
);

	// ---------------------------------------------------------------- config
	logic signed [agti_pkg::ENTRY_W-1:0] peak_q;
	logic                                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	// Single register: decode the word index, ignore byte lanes
	assign prdata = (paddr[agti_pkg::CFG_ADDR_W-1:2] == agti_pkg::REG_PEAK_GAIN)
		? agti_pkg::CFG_DATA_W'(peak_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cfg_wr && paddr[agti_pkg::CFG_ADDR_W-1:2] == agti_pkg::REG_PEAK_GAIN) begin
			peak_q <= pwdata[agti_pkg::ENTRY_W-1:0];
		end
	end

	// -------------------------------------------------------- clearing pass
	logic                       clr_busy_q;
	logic [agti_pkg::IDX_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == agti_pkg::IDX_W'(agti_pkg::TABLE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------ input register
	logic                                queue_full;
	logic                                item_acc;
	logic                                query_acc;
	logic                                v_s1;
	logic [agti_pkg::OP_W-1:0]           op_s1;
	logic [agti_pkg::IDX_W-1:0]          idx_s1;
	logic signed [agti_pkg::ENTRY_W-1:0] entry_s1;
	logic signed [agti_pkg::AZ_W-1:0]    az_s1;
	logic signed [agti_pkg::EL_W-1:0]    el_s1;

	// Hold off transactions while clearing or when result credits run out
	assign item_stall = clr_busy_q || queue_full;
	assign item_acc   = item_valid && !item_stall;
	assign query_acc  = item_acc && operation == agti_pkg::OP_QUERY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= item_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_s1    <= operation;
			idx_s1   <= table_index;
			entry_s1 <= entry_gain;
			az_s1    <= azimuth;
			el_s1    <= elevation;
		end
	end

	// --------------------------------------- stage 1: wrap angles, index RAM
	logic [agti_pkg::ANGLE_W-1:0]   ang_h;
	logic [agti_pkg::ANGLE_W-1:0]   ang_v;
	logic signed [agti_pkg::AZ_W-1:0] el_neg;
	logic [agti_pkg::IDX_W-1:0]     lo_h;
	logic [agti_pkg::IDX_W-1:0]     hi_h;
	logic [agti_pkg::IDX_W-1:0]     lo_v;
	logic [agti_pkg::IDX_W-1:0]     hi_v;
	logic                           is_query;
	logic                           wr_ok;
	agti_pkg::ram_wr_t              h_wr;
	agti_pkg::ram_wr_t              v_wr;

	always_comb begin
		// Vertical angle runs opposite to elevation
		el_neg = agti_pkg::AZ_W'(-int'(el_s1));
		ang_h  = agti_pkg::wrap_angle(az_s1);
		ang_v  = agti_pkg::wrap_angle(el_neg);
		lo_h   = ang_h[agti_pkg::ANGLE_W-1:agti_pkg::FRAC_BITS];
		lo_v   = ang_v[agti_pkg::ANGLE_W-1:agti_pkg::FRAC_BITS];
		// Wrap the upper neighbour from the last degree back to zero
		hi_h   = (lo_h == agti_pkg::IDX_W'(agti_pkg::TABLE_DEPTH - 1)) ? '0 : lo_h + 1'b1;
		hi_v   = (lo_v == agti_pkg::IDX_W'(agti_pkg::TABLE_DEPTH - 1)) ? '0 : lo_v + 1'b1;
	end

	always_comb begin
		is_query = 1'b0;
		wr_ok    = idx_s1 < agti_pkg::IDX_W'(agti_pkg::TABLE_DEPTH);
		h_wr.we  = clr_busy_q;
		v_wr.we  = clr_busy_q;
		case (op_s1)
			agti_pkg::OP_QUERY:    is_query = v_s1;
			agti_pkg::OP_WR_HORIZ: h_wr.we  = clr_busy_q || (v_s1 && wr_ok);
			agti_pkg::OP_WR_VERT:  v_wr.we  = clr_busy_q || (v_s1 && wr_ok);
			default:               is_query = 1'b0;
		endcase
		// Clearing pass owns the write port until it finishes
		h_wr.addr = clr_busy_q ? clr_addr_q : idx_s1;
		h_wr.data = clr_busy_q ? '0 : entry_s1;
		v_wr.addr = h_wr.addr;
		v_wr.data = h_wr.data;
	end

	// ----------------------------------------------- stage 2: table read
	logic                                 qv_s2;
	logic [agti_pkg::FRAC_BITS-1:0]       frac_h_s2;
	logic [agti_pkg::FRAC_BITS-1:0]       frac_v_s2;
	logic signed [agti_pkg::ENTRY_W-1:0]  h_lo_s2;
	logic signed [agti_pkg::ENTRY_W-1:0]  h_hi_s2;
	logic signed [agti_pkg::ENTRY_W-1:0]  v_lo_s2;
	logic signed [agti_pkg::ENTRY_W-1:0]  v_hi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s2 <= 1'b0;
		end else begin
			qv_s2 <= is_query;
		end
	end

	always_ff @(posedge clk) begin
		frac_h_s2 <= ang_h[agti_pkg::FRAC_BITS-1:0];
		frac_v_s2 <= ang_v[agti_pkg::FRAC_BITS-1:0];
	end

	agti_table_ram u_h_ram (
		.clk        (clk),
		.wr         (h_wr),
		.rd_addr_lo (lo_h),
		.rd_addr_hi (hi_h),
		.rd_lo_s2   (h_lo_s2),
		.rd_hi_s2   (h_hi_s2)
	);

	agti_table_ram u_v_ram (
		.clk        (clk),
		.wr         (v_wr),
		.rd_addr_lo (lo_v),
		.rd_addr_hi (hi_v),
		.rd_lo_s2   (v_lo_s2),
		.rd_hi_s2   (v_hi_s2)
	);

	// -------------------------------------------- stage 3: interpolation
	logic                                qv_s3;
	logic signed [agti_pkg::ENTRY_W-1:0] atten_h_s3;
	logic signed [agti_pkg::ENTRY_W-1:0] atten_v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s3 <= 1'b0;
		end else begin
			qv_s3 <= qv_s2;
		end
	end

	agti_interp u_h_interp (
		.clk      (clk),
		.lo       (h_lo_s2),
		.hi       (h_hi_s2),
		.frac     (frac_h_s2),
		.atten_s3 (atten_h_s3)
	);

	agti_interp u_v_interp (
		.clk      (clk),
		.lo       (v_lo_s2),
		.hi       (v_hi_s2),
		.frac     (frac_v_s2),
		.atten_s3 (atten_v_s3)
	);

	// ------------------------------------- gain sum, saturate, result queue
	logic signed [agti_pkg::GAIN_W:0]   g_full;
	logic signed [agti_pkg::GAIN_W-1:0] g_sat;

	always_comb begin
		g_full = (agti_pkg::GAIN_W + 1)'(peak_q)
			- ((agti_pkg::GAIN_W + 1)'(atten_h_s3) + (agti_pkg::GAIN_W + 1)'(atten_v_s3));
		if (g_full > (agti_pkg::GAIN_W + 1)'(agti_pkg::GAIN_MAX)) begin
			g_sat = agti_pkg::GAIN_W'(agti_pkg::GAIN_MAX);
		end else if (g_full < (agti_pkg::GAIN_W + 1)'(agti_pkg::GAIN_MIN)) begin
			g_sat = agti_pkg::GAIN_W'(agti_pkg::GAIN_MIN);
		end else begin
			g_sat = agti_pkg::GAIN_W'(g_full);
		end
	end

	agti_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (query_acc),
		.push      (qv_s3),
		.push_data (g_sat),
		.pop       (gain_valid && !gain_stall),
		.valid     (gain_valid),
		.data      (total_gain),
		.full      (queue_full)
	);

	`AGTI_ASSERT_NEXT(a_clr_blocks_items, clk, arst_n, clr_busy_q, !v_s1)
	`AGTI_ASSERT(a_query_latency, clk, arst_n, query_acc |-> ##3 qv_s3)
	`AGTI_ASSERT(a_wr_in_range, clk, arst_n, (h_wr.we || v_wr.we) |-> (h_wr.addr < agti_pkg::IDX_W'(agti_pkg::TABLE_DEPTH)))

endmodule

// ----- rtl/agti_table_ram.sv -----
// ----------------------------------------------------------------------------
// Attenuation table memory
// One write port and two registered read ports, one entry per degree.
// ----------------------------------------------------------------------------
module agti_table_ram (
	input  logic                                clk,
	input  agti_pkg::ram_wr_t                   wr,
	input  logic [agti_pkg::IDX_W-1:0]          rd_addr_lo,
	input  logic [agti_pkg::IDX_W-1:0]          rd_addr_hi,
	output logic signed [agti_pkg::ENTRY_W-1:0] rd_lo_s2,
	output logic signed [agti_pkg::ENTRY_W-1:0] rd_hi_s2
);

	logic signed [agti_pkg::ENTRY_W-1:0] mem_q [agti_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_lo_s2 <= mem_q[rd_addr_lo];
		rd_hi_s2 <= mem_q[rd_addr_hi];
	end

endmodule

// ----- rtl/agti_interp.sv -----
// ----------------------------------------------------------------------------
// Linear interpolator
// Blend two adjacent entries by the angle fraction, rounding toward minus
// infinity, and register the attenuation.
// ----------------------------------------------------------------------------
module agti_interp (
	input  logic                                clk,
	input  logic signed [agti_pkg::ENTRY_W-1:0] lo,
	input  logic signed [agti_pkg::ENTRY_W-1:0] hi,
	input  logic [agti_pkg::FRAC_BITS-1:0]      frac,
	output logic signed [agti_pkg::ENTRY_W-1:0] atten_s3
);

	localparam int PROD_W = agti_pkg::ENTRY_W + agti_pkg::FRAC_BITS + 2;

	logic signed [agti_pkg::ENTRY_W:0] diff;
	logic signed [PROD_W-1:0]          prod;
	logic signed [PROD_W-1:0]          step;
	logic signed [agti_pkg::ENTRY_W:0] sum;

	// lo*(1-f) + hi*f == lo + (hi-lo)*f, exact under the floor shift
	always_comb begin
		diff = (agti_pkg::ENTRY_W + 1)'(hi) - (agti_pkg::ENTRY_W + 1)'(lo);
		prod = diff * $signed({1'b0, frac});
		step = prod >>> agti_pkg::FRAC_BITS;
		sum  = (agti_pkg::ENTRY_W + 1)'(lo) + (agti_pkg::ENTRY_W + 1)'(step);
	end

	always_ff @(posedge clk) begin
		atten_s3 <= agti_pkg::ENTRY_W'(sum);
	end

endmodule

// ----- rtl/agti_out_queue.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Small FIFO with an outstanding-query count that throttles the input.
// ----------------------------------------------------------------------------
`include "antenna_gain_table_interpolator_top_defines.svh"

module agti_out_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               take,
	input  logic                               push,
	input  logic signed [agti_pkg::GAIN_W-1:0] push_data,
	input  logic                               pop,
	output logic                               valid,
	output logic signed [agti_pkg::GAIN_W-1:0] data,
	output logic                               full
);

	logic signed [agti_pkg::GAIN_W-1:0] fifo_q [agti_pkg::QUEUE_DEPTH];
	logic [agti_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [agti_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [agti_pkg::QCNT_W-1:0]        fill_q;
	logic [agti_pkg::QCNT_W-1:0]        outst_q;

	function automatic logic [agti_pkg::QCNT_W-1:0] QCNT_W_ONE(input logic b);
		return agti_pkg::QCNT_W'(b);
	endfunction

	assign valid = (fill_q != '0);
	assign data  = fifo_q[rd_ptr_q];
	assign full  = (outst_q == agti_pkg::QCNT_W'(agti_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			outst_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q  <= fill_q + QCNT_W_ONE(push) - QCNT_W_ONE(pop);
			outst_q <= outst_q + QCNT_W_ONE(take) - QCNT_W_ONE(pop);
		end
	end

	`AGTI_ASSERT(a_fill_le_outst, clk, arst_n, (fill_q <= outst_q))
	`AGTI_ASSERT(a_outst_bound, clk, arst_n, (outst_q <= agti_pkg::QCNT_W'(agti_pkg::QUEUE_DEPTH)))
	`AGTI_ASSERT(a_no_overflow, clk, arst_n, push |-> (fill_q < agti_pkg::QCNT_W'(agti_pkg::QUEUE_DEPTH)))

endmodule

// ----- tb/antenna_gain_table_interpolator_top_tb.sv -----
// ----------------------------------------------------------------------------
// Antenna gain table interpolator testbench
// Loads both attenuation tables and queries gains through the item channel.
// A local predictor tracks the tables and the peak gain and works out each
// expected gain result. Results are checked in order against that prediction.
// Both channels idle at random, and one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module antenna_gain_table_interpolator_top_tb;
	import agti_pkg::*;

	localparam int PEAK_W        = 16;
	localparam int SETTLE_CYCLES = 8;     // lets trailing table writes leave the pipeline
	localparam int IDLE_LIMIT    = 3000;  // covers the clearing pass and the long hold
	localparam int HOLD_CYCLES   = 150;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] PEAK_GAIN_ADDR = CFG_ADDR_W'(4 * int'(REG_PEAK_GAIN));

	typedef struct {
		logic [OP_W-1:0]           op;
		logic [IDX_W-1:0]          idx;
		logic signed [ENTRY_W-1:0] entry;
		logic signed [AZ_W-1:0]    az;
		logic signed [EL_W-1:0]    el;
	} gain_item_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic [OP_W-1:0]            operation = '0;
	logic [IDX_W-1:0]           table_index = '0;
	logic signed [ENTRY_W-1:0]  entry_gain = '0;
	logic signed [AZ_W-1:0]     azimuth = '0;
	logic signed [EL_W-1:0]     elevation = '0;
	logic                       gain_valid;
	logic                       gain_stall = 1'b0;
	logic signed [GAIN_W-1:0]   total_gain;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]      paddr = '0;
	logic [CFG_DATA_W-1:0]      pwdata = '0;
	logic [CFG_DATA_W-1:0]      prdata;
	logic                       pready;

	antenna_gain_table_interpolator_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.operation(operation), .table_index(table_index), .entry_gain(entry_gain),
		.azimuth(azimuth), .elevation(elevation),
		.gain_valid(gain_valid), .gain_stall(gain_stall), .total_gain(total_gain),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: both attenuation tables and the peak gain register
	logic signed [ENTRY_W-1:0] horiz_atten [TABLE_DEPTH];
	logic signed [ENTRY_W-1:0] vert_atten  [TABLE_DEPTH];
	logic signed [PEAK_W-1:0]  peak_setting = '0;

	gain_item_t               pending_items [$];
	logic signed [GAIN_W-1:0] gain_expected [$];

	int unsigned items_offered = 0;
	int unsigned items_taken = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count = 0;
	int unsigned query_count = 0;
	int unsigned write_count = 0;
	int unsigned ignored_count = 0;
	int unsigned settings_used = 0;
	int unsigned idle_cycles = 0;

	// Stimulus shaping
	int  gap_left = 0;
	int  quiet_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  drv_roll;
	int  stall_roll;
	bit  burst_phase = 1'b0;
	bit  pressure_armed = 1'b0;
	int  last_h_idx = 0;
	int  last_v_idx = 0;

	logic signed [GAIN_W-1:0] want_gain;
	gain_item_t               seen_item;

	// Clock: 12 time units per period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Wrap an angle onto one turn and blend the two neighbouring whole-degree
	// entries; the weighted sum is floored by the arithmetic shift.
	function automatic longint interp_attenuation(input bit vertical, input longint angle);
		longint circle;
		longint wrapped;
		longint frac;
		longint acc;
		longint lo_val;
		longint hi_val;
		int     lo;
		int     hi;
		circle  = longint'(TABLE_DEPTH) << FRAC_BITS;
		wrapped = angle % circle;
		if (wrapped < 0) begin
			wrapped = wrapped + circle;
		end
		frac = wrapped & ((longint'(1) << FRAC_BITS) - 1);
		lo   = int'(wrapped >>> FRAC_BITS);
		hi   = (lo + 1) % TABLE_DEPTH;
		if (vertical) begin
			lo_val = longint'(vert_atten[lo]);
			hi_val = longint'(vert_atten[hi]);
		end else begin
			lo_val = longint'(horiz_atten[lo]);
			hi_val = longint'(horiz_atten[hi]);
		end
		acc = lo_val * ((longint'(1) << FRAC_BITS) - frac) + hi_val * frac;
		return acc >>> FRAC_BITS;
	endfunction

	// Apply one accepted transaction to the predictor state
	function automatic void predict_gain(input gain_item_t it);
		longint g;
		if (it.op == OP_WR_HORIZ || it.op == OP_WR_VERT) begin
			if (it.idx < TABLE_DEPTH) begin
				if (it.op == OP_WR_HORIZ) begin
					horiz_atten[it.idx] = it.entry;
				end else begin
					vert_atten[it.idx] = it.entry;
				end
				write_count++;
			end else begin
				ignored_count++;
			end
		end else if (it.op == OP_QUERY) begin
			g = longint'(peak_setting)
				- (interp_attenuation(1'b0, longint'(it.az))
				+ interp_attenuation(1'b1, -longint'(it.el)));
			if (g > GAIN_MAX) begin
				g = GAIN_MAX;
			end
			if (g < GAIN_MIN) begin
				g = GAIN_MIN;
			end
			gain_expected.insert(gain_expected.size(), GAIN_W'(g));
			query_count++;
		end else begin
			ignored_count++;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------------

	function automatic logic signed [ENTRY_W-1:0] random_entry();
		if ($urandom_range(99) < 25) begin
			return ENTRY_W'($urandom);
		end
		return ENTRY_W'(int'($urandom_range(15360)) - 7680);
	endfunction

	// Often near a recently written entry, so the interpolation sees data
	function automatic logic signed [AZ_W-1:0] random_azimuth();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			return AZ_W'((last_h_idx << FRAC_BITS) + int'($urandom_range((1 << FRAC_BITS) - 1)));
		end
		if (pick < 70) begin
			return AZ_W'($urandom_range(CIRCLE - 1));
		end
		if (pick < 88) begin
			return AZ_W'(int'($urandom_range(3 * CIRCLE - 1)) - CIRCLE);
		end
		return AZ_W'($urandom);
	endfunction

	// The vertical lookup angle is the negated elevation
	function automatic logic signed [EL_W-1:0] random_elevation();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			return EL_W'(-((last_v_idx << FRAC_BITS)
				+ int'($urandom_range((1 << FRAC_BITS) - 1))));
		end
		if (pick < 70) begin
			return EL_W'(int'($urandom_range(CIRCLE / 2)) - CIRCLE / 4);
		end
		if (pick < 88) begin
			return EL_W'(int'($urandom_range(2 * CIRCLE)) - CIRCLE);
		end
		return EL_W'($urandom);
	endfunction

	function automatic void queue_item(input logic [OP_W-1:0] op, input int idx,
		input logic signed [ENTRY_W-1:0] entry, input logic signed [AZ_W-1:0] az,
		input logic signed [EL_W-1:0] el);
		gain_item_t it;
		it.op    = op;
		it.idx   = IDX_W'(idx);
		it.entry = entry;
		it.az    = az;
		it.el    = el;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Unused fields carry random values so every bit toggles
	function automatic void queue_write(input logic [OP_W-1:0] op, input int idx,
		input logic signed [ENTRY_W-1:0] entry);
		if (idx < TABLE_DEPTH) begin
			if (op == OP_WR_HORIZ) begin
				last_h_idx = idx;
			end else begin
				last_v_idx = idx;
			end
		end
		queue_item(op, idx, entry, AZ_W'($urandom), EL_W'($urandom));
	endfunction

	function automatic void queue_query(input logic signed [AZ_W-1:0] az,
		input logic signed [EL_W-1:0] el);
		queue_item(OP_QUERY, int'($urandom_range((1 << IDX_W) - 1)), ENTRY_W'($urandom), az, el);
	endfunction

	function automatic void queue_random_items(input int count, input int write_share);
		int pick;
		int idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < write_share) begin
				if ($urandom_range(9) == 0) begin
					idx = $urandom_range((1 << IDX_W) - 1, TABLE_DEPTH);
				end else begin
					idx = $urandom_range(TABLE_DEPTH - 1);
				end
				queue_write($urandom_range(1) ? OP_WR_HORIZ : OP_WR_VERT, idx, random_entry());
			end else if (pick < write_share + 3) begin
				queue_item(OP_UNUSED, int'($urandom_range((1 << IDX_W) - 1)),
					ENTRY_W'($urandom), AZ_W'($urandom), EL_W'($urandom));
			end else begin
				queue_query(random_azimuth(), random_elevation());
			end
		end
	endfunction

	// Write the peak gain register, then read it back
	task automatic set_peak_gain(input logic signed [PEAK_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PEAK_GAIN_ADDR;
		pwdata  <= {{(CFG_DATA_W - PEAK_W){value[PEAK_W-1]}}, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		peak_setting = value;
		settings_used++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[PEAK_W-1:0] !== value) begin
			report_mismatch($sformatf("peak gain reads %0d, written %0d",
				$signed(prdata[PEAK_W-1:0]), value));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Wait until every transaction is taken and every result has arrived, then
	// let trailing table writes leave the pipeline
	task automatic settle_block();
		while (pending_items.size() != 0 || items_taken != items_offered
			|| gain_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Sequence of phases
	// ------------------------------------------------------------------------
	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			horiz_atten[i] = '0;
			vert_atten[i]  = '0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		set_peak_gain(16'sd0);

		// Directed: field extremes, wrap of the index from 359 to 0, ignored
		// items, angles far outside one turn
		queue_write(OP_WR_HORIZ, 0, 16'sh7fff);
		queue_write(OP_WR_HORIZ, 1, 16'sh8000);
		queue_write(OP_WR_HORIZ, TABLE_DEPTH - 1, 16'sh8000);
		queue_write(OP_WR_HORIZ, 180, 16'sd1);
		queue_write(OP_WR_VERT, 0, 16'sh7fff);
		queue_write(OP_WR_VERT, TABLE_DEPTH - 1, 16'sh7fff);
		queue_write(OP_WR_VERT, 1, -16'sd1);
		queue_write(OP_WR_HORIZ, TABLE_DEPTH, 16'sh5555);
		queue_write(OP_WR_VERT, (1 << IDX_W) - 1, 16'shaaaa);
		queue_item(OP_UNUSED, (1 << IDX_W) - 1, 16'sh7fff, '1, '1);
		queue_query('0, '0);
		queue_query(AZ_W'((1 << FRAC_BITS) - 1), '0);
		queue_query(AZ_W'(((TABLE_DEPTH - 1) << FRAC_BITS) + (1 << (FRAC_BITS - 1))), '0);
		queue_query(AZ_W'(-CIRCLE), '0);
		queue_query(AZ_W'(2 * CIRCLE - 1), '0);
		queue_query({1'b1, {(AZ_W - 1){1'b0}}}, {1'b1, {(EL_W - 1){1'b0}}});
		queue_query({1'b0, {(AZ_W - 1){1'b1}}}, {1'b0, {(EL_W - 1){1'b1}}});
		queue_query(AZ_W'(180 << FRAC_BITS), EL_W'(CIRCLE / 4));
		queue_query('0, EL_W'(-((1 << FRAC_BITS) + (1 << (FRAC_BITS - 1)))));
		queue_query('0, EL_W'(1 << (FRAC_BITS - 1)));
		queue_write(OP_WR_HORIZ, 0, 16'sh8000);
		queue_query('0, '0);
		settle_block();

		// Table loading with the largest peak gain
		set_peak_gain(16'sh7fff);
		queue_random_items(150, 60);
		settle_block();

		// Smallest peak gain; no sender gaps and a long receiver hold
		set_peak_gain(16'sh8000);
		burst_phase = 1'b1;
		queue_random_items(150, 30);
		pressure_armed = 1'b1;
		settle_block();
		burst_phase = 1'b0;

		set_peak_gain(PEAK_W'($urandom));
		queue_random_items(150, 30);
		settle_block();

		$display("Covered %0d transactions: %0d queries, %0d table writes, %0d ignored.",
			items_taken, query_count, write_count, ignored_count);
		$display("Checked %0d gain results over %0d peak gain settings.",
			results_checked, settings_used);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Item driver: present one pending transaction at a time, hold it until
	// taken, then idle for a random gap
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!item_valid || items_taken == items_offered)) begin
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left--;
			end else if (pending_items.size() > 0) begin
				seen_item = pending_items.pop_front();
				item_valid  <= 1'b1;
				operation   <= seen_item.op;
				table_index <= seen_item.idx;
				entry_gain  <= seen_item.entry;
				azimuth     <= seen_item.az;
				elevation   <= seen_item.el;
				items_offered++;
				// Choose the gap that follows this transaction
				drv_roll = $urandom_range(99);
				if (burst_phase) begin
					gap_left = 0;
				end else if (quiet_left > 0) begin
					quiet_left--;
					gap_left = 0;
				end else if (drv_roll < 5) begin
					quiet_left = $urandom_range(40, 20);
					gap_left = 0;
				end else if (drv_roll < 55) begin
					gap_left = 0;
				end else if (drv_roll < 90) begin
					gap_left = $urandom_range(3, 1);
				end else begin
					gap_left = $urandom_range(30, 6);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Gain receiver: random stalls, plus one long hold while the sender keeps
	// offering, so that the result queue fills and the item channel backs up
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			gain_stall <= 1'b1;
			hold_left--;
		end else if (pressure_armed && pending_items.size() >= 40) begin
			pressure_armed = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			gain_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			stall_roll = $urandom_range(99);
			if (stall_roll < 45) begin
				gain_stall <= 1'b0;
				stall_left = $urandom_range(8, 0);
			end else if (stall_roll < 50) begin
				gain_stall <= 1'b0;
				stall_left = $urandom_range(60, 30);
			end else if (stall_roll < 88) begin
				gain_stall <= 1'b1;
				stall_left = $urandom_range(2, 0);
			end else begin
				gain_stall <= 1'b1;
				stall_left = $urandom_range(25, 5);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check results before taking new transactions, so a query
	// accepted in the same cycle never pairs with an earlier result
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (gain_valid && !gain_stall) begin
				results_checked++;
				if (gain_expected.size() == 0) begin
					report_mismatch($sformatf("total_gain %0d with no query waiting", total_gain));
				end else begin
					want_gain = gain_expected.pop_front();
					if (total_gain !== want_gain) begin
						report_mismatch($sformatf("total_gain %0d, predicted %0d (result %0d)",
							total_gain, want_gain, results_checked));
					end
				end
			end
			if (item_valid && !item_stall) begin
				seen_item.op    = operation;
				seen_item.idx   = table_index;
				seen_item.entry = entry_gain;
				seen_item.az    = azimuth;
				seen_item.el    = elevation;
				predict_gain(seen_item);
				items_taken++;
			end
			// Watchdog: count cycles in which no channel moves a transaction
			if ((item_valid && !item_stall) || (gain_valid && !gain_stall)
				|| (psel && penable && pready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					idle_cycles, gain_expected.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
